// ----- rtl/zais_pkg.sv -----
// ----------------------------------------------------------------------------
// zais_pkg
// Shared types and constants for the zone aware I/O splitter.
// ----------------------------------------------------------------------------
package zais_pkg;

  // address width and chunk limit per request
  localparam int LBA_W      = 48;
  localparam int MAX_CHUNKS = 64;
  localparam int CNT_W      = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

  // field widths
  localparam int SIZE_W  = 32;
  localparam int BLK_W   = 32;
  localparam int STEP_W  = 21;
  localparam int OFFS_W  = 24;
  localparam int NEXT_W  = 49;
  localparam int SHIFT_W = 5;

  // stream and register port widths
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 144;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;

  // classified request queue
  localparam int Q_DEPTH = 2;
  localparam int QP_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  // remainder divider
  localparam int DIV_CNT_W = $clog2(LBA_W);

  // register indexes (byte address 8*i)
  typedef enum logic [2:0] {
    REG_BLOCK_SHIFT  = 3'd0,
    REG_ZONE_BLOCKS  = 3'd1,
    REG_READ_STEP    = 3'd2,
    REG_APPEND_STEP  = 3'd3,
    REG_WIN_FIRST    = 3'd4,
    REG_WIN_END      = 3'd5
  } reg_idx_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OUT   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_LIMIT = 2'd3
  } status_t;

  // request classification from the front part
  typedef enum logic [1:0] {
    KIND_OK,
    KIND_OUT,
    KIND_EMPTY
  } req_kind_t;

  // back part sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_CHUNK
  } back_state_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] block_shift;
    logic [31:0]        zone_blocks;
    logic [STEP_W-1:0]  read_step;
    logic [STEP_W-1:0]  append_step;
    logic [LBA_W-1:0]   win_first;
    logic [LBA_W-1:0]   win_end;
  } cfg_t;

  typedef struct packed {
    logic             func;
    logic [LBA_W-1:0] start_lba;
    logic [BLK_W-1:0] blocks;
    req_kind_t        kind;
  } q_entry_t;

  typedef struct packed {
    logic             start;
    logic [LBA_W-1:0] dividend;
    logic [31:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

// ----- rtl/zais_front.sv -----
// ----------------------------------------------------------------------------
// zais_front
// Accepts requests, converts bytes to blocks and classifies them against the
// owned window before they enter the queue.
// ----------------------------------------------------------------------------
module zais_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  zais_pkg::cfg_t           cfg,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic                     in_func,
  input  logic [zais_pkg::LBA_W-1:0]  in_start_lba,
  input  logic [zais_pkg::SIZE_W-1:0] in_byte_size,
  output logic                     push,
  output zais_pkg::q_entry_t       push_entry,
  input  logic                     q_ready
);
  import zais_pkg::*;

  logic             s0_valid_r, s0_valid_nxt;
  logic             s0_func_r;
  logic [LBA_W-1:0] s0_start_r;
  logic [BLK_W-1:0] s0_blocks_r;
  logic             s0_lt_first_r;
  logic             s0_gt_end_r;

  logic             accept;
  logic [SIZE_W:0]  unit_less;
  logic [SIZE_W:0]  round_sum;
  logic [SIZE_W:0]  round_blk;
  logic [LBA_W-1:0] room;
  logic             too_long;

  assign in_tready = !s0_valid_r || q_ready;
  assign accept    = in_tvalid && in_tready;

  // round the byte size up to whole blocks
  assign unit_less = ((SIZE_W+1)'(1) << cfg.block_shift) - (SIZE_W+1)'(1);
  assign round_sum = {1'b0, in_byte_size} + unit_less;
  assign round_blk = round_sum >> cfg.block_shift;

  always_comb begin
    s0_valid_nxt = s0_valid_r;
    if (accept) begin
      s0_valid_nxt = 1'b1;
    end else if (q_ready) begin
      s0_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
    end
  end

  // first stage: block count and start compares
  always_ff @(posedge clk) begin
    if (accept) begin
      s0_func_r     <= in_func;
      s0_start_r    <= in_start_lba;
      s0_blocks_r   <= round_blk[BLK_W-1:0];
      s0_lt_first_r <= in_start_lba < cfg.win_first;
      s0_gt_end_r   <= in_start_lba > cfg.win_end;
    end
  end

  // second stage: length against room left in the window
  assign room     = cfg.win_end - s0_start_r;
  assign too_long = LBA_W'(s0_blocks_r) > room;

  always_comb begin
    push_entry.func      = s0_func_r;
    push_entry.start_lba = s0_start_r;
    push_entry.blocks    = s0_blocks_r;
    priority if (s0_lt_first_r || s0_gt_end_r || too_long) begin
      push_entry.kind = KIND_OUT;
    end else if (s0_blocks_r == '0) begin
      push_entry.kind = KIND_EMPTY;
    end else begin
      push_entry.kind = KIND_OK;
    end
  end

  assign push = s0_valid_r && q_ready;

endmodule

// ----- rtl/zais_queue.sv -----
// ----------------------------------------------------------------------------
// zais_queue
// Short queue of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
module zais_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  zais_pkg::q_entry_t push_entry,
  output logic               q_ready,
  input  logic               pop,
  output logic               q_valid,
  output zais_pkg::q_entry_t head
);
  import zais_pkg::*;

  q_entry_t        mem [Q_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] count_r, count_nxt;

  assign q_ready = count_r != QC_W'(Q_DEPTH);
  assign q_valid = count_r != '0;
  assign head    = mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QP_W'(Q_DEPTH-1)) ? '0 : wr_ptr_r + QP_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QP_W'(Q_DEPTH-1)) ? '0 : rd_ptr_r + QP_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QC_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- rtl/zais_div.sv -----
// ----------------------------------------------------------------------------
// zais_div
// Restoring divider, one dividend bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module zais_div (
  input  logic               clk,
  input  logic               rst_n,
  input  zais_pkg::div_req_t req,
  output zais_pkg::div_rsp_t rsp
);
  import zais_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [LBA_W-1:0]     dvd_r;
  logic [31:0]          dvs_r;
  logic [31:0]          rem_r;
  logic [32:0]          trial;
  logic                 fits;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem_r, dvd_r[LBA_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= DIV_CNT_W'(LBA_W-1);
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - DIV_CNT_W'(1);
      dvd_r <= {dvd_r[LBA_W-2:0], 1'b0};
      rem_r <= fits ? 32'(trial - {1'b0, dvs_r}) : trial[31:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// ----- rtl/zais_back.sv -----
// ----------------------------------------------------------------------------
// zais_back
// Takes classified requests from the queue and emits one result word per
// chunk, never crossing a zone edge or the per-mode step.
// ----------------------------------------------------------------------------
module zais_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  zais_pkg::cfg_t                cfg,
  input  logic                          q_valid,
  input  zais_pkg::q_entry_t            head,
  output logic                          pop,
  output zais_pkg::div_req_t            div_req,
  input  zais_pkg::div_rsp_t            div_rsp,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [zais_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                    out_tuser,
  output logic                          out_tlast
);
  import zais_pkg::*;

  back_state_t state_r, state_nxt;

  logic              func_r;
  logic [LBA_W-1:0]  start_r;
  logic [LBA_W-1:0]  cur_r;
  logic [LBA_W-1:0]  base_r;
  logic [BLK_W-1:0]  left_r;
  logic [OFFS_W-1:0] done_r;
  logic [31:0]       to_edge_r;
  logic [CNT_W-1:0]  n_r;

  logic              out_valid_r;
  logic [LBA_W-1:0]  o_lba_r;
  logic [STEP_W-1:0] o_blocks_r;
  logic [OFFS_W-1:0] o_offs_r;
  logic [NEXT_W-1:0] o_next_r;
  status_t           o_status_r;
  logic              o_last_r;

  logic              out_free;
  logic              emit_special;
  logic              emit_chunk;
  logic [31:0]       zone_eff;
  logic [STEP_W-1:0] step_raw;
  logic [STEP_W-1:0] step_eff;
  logic [31:0]       edge_or_left;
  logic [STEP_W-1:0] cs;
  logic              chunk_last;
  logic              at_limit;
  logic              edge_hit;

  assign out_free = !out_valid_r || out_tready;

  // zero registers act as one
  assign zone_eff = (cfg.zone_blocks == '0) ? 32'd1 : cfg.zone_blocks;
  assign step_raw = func_r ? cfg.append_step : cfg.read_step;
  assign step_eff = (step_raw == '0) ? STEP_W'(1) : step_raw;

  // chunk size: least of step, blocks to the zone edge and blocks left
  assign edge_or_left = (to_edge_r < left_r) ? to_edge_r : left_r;
  assign cs = (32'(step_eff) < edge_or_left) ? step_eff : edge_or_left[STEP_W-1:0];
  assign chunk_last = 32'(cs) == left_r;
  assign at_limit   = n_r == CNT_W'(MAX_CHUNKS-1);
  assign edge_hit   = 32'(cs) == to_edge_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid && head.kind == KIND_OK) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_CHUNK;
        end
      end
      S_CHUNK: begin
        if (out_free && (chunk_last || at_limit)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop              = 1'b0;
    emit_special     = 1'b0;
    emit_chunk       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = head.start_lba;
    div_req.divisor  = zone_eff;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid && head.kind == KIND_OK) begin
          pop           = 1'b1;
          div_req.start = 1'b1;
        end else if (q_valid && out_free) begin
          pop          = 1'b1;
          emit_special = 1'b1;
        end
      end
      S_CHUNK: begin
        emit_chunk = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_special || emit_chunk) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // per-request walk state
  always_ff @(posedge clk) begin
    if (div_req.start) begin
      func_r  <= head.func;
      start_r <= head.start_lba;
      cur_r   <= head.start_lba;
      left_r  <= head.blocks;
      done_r  <= '0;
      n_r     <= '0;
    end else if (state_r == S_DIV && div_rsp.done) begin
      to_edge_r <= zone_eff - div_rsp.rem;
      base_r    <= start_r - LBA_W'(div_rsp.rem);
    end else if (emit_chunk) begin
      cur_r  <= cur_r + LBA_W'(cs);
      left_r <= left_r - 32'(cs);
      done_r <= done_r + OFFS_W'(cs);
      n_r    <= n_r + CNT_W'(1);
      if (edge_hit) begin
        to_edge_r <= zone_eff;
        base_r    <= base_r + LBA_W'(zone_eff);
      end else begin
        to_edge_r <= to_edge_r - 32'(cs);
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (emit_special) begin
      o_lba_r    <= '0;
      o_blocks_r <= '0;
      o_offs_r   <= '0;
      o_next_r   <= NEXT_W'(head.start_lba);
      o_status_r <= (head.kind == KIND_OUT) ? ST_OUT : ST_EMPTY;
      o_last_r   <= 1'b1;
    end else if (emit_chunk) begin
      o_lba_r    <= func_r ? base_r : cur_r;
      o_blocks_r <= cs;
      o_offs_r   <= done_r;
      o_next_r   <= NEXT_W'(cur_r) + NEXT_W'(cs);
      o_status_r <= (!chunk_last && at_limit) ? ST_LIMIT : ST_OK;
      o_last_r   <= chunk_last || at_limit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, o_next_r, o_offs_r, o_blocks_r, o_lba_r};
  assign out_tuser  = o_status_r;
  assign out_tlast  = o_last_r;

`ifndef NO_ASSERTIONS
  // a chunk always moves at least one block
  a_chunk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    emit_chunk |-> cs != '0)
    else $error("empty chunk emitted");

  // the zone edge distance stays within one zone while walking
  a_edge_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHUNK |-> (to_edge_r != '0 && to_edge_r <= zone_eff))
    else $error("zone edge distance out of range");

  // a walk never runs with nothing left
  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHUNK |-> left_r != '0)
    else $error("chunk walk with no blocks left");

  // the divider answers before the walk starts
  a_div_then_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_rsp.done) |=> state_r == S_CHUNK)
    else $error("walk did not start after division");
`endif

endmodule

// ----- rtl/zone_aware_io_splitter_top.sv -----
// ----------------------------------------------------------------------------
// zone_aware_io_splitter_top
// Splits read and zone append requests into zone-bounded commands.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request word per handshake, func in tuser, LBA and bytes in tdata
//   out_* : one result word per chunk, status in tuser, tlast on the final one
//   cfg_* : register port, 64-bit data, register i at byte address 8*i,
//           written with psel/penable/pwrite, pready tied high
// Flow:
//   the front part registers an accepted word for the window checks,
//   then writes it to the queue; a rejected or empty request gives its
//   result word from the output register once the back part is idle
//   an accepted request first runs through the remainder divider; its
//   chunk words then follow at one chunk per cycle while the output is not
//   held, and the back part takes no new request until its last chunk (at most 64)
// Reset: clears the queue, the sequencer and the output register and loads
//   the register defaults; no clearing pass is needed
// Stall: a held result word stops the chunk walk; the queue then fills and
//   in_tready drops
// ----------------------------------------------------------------------------
module zone_aware_io_splitter_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: start_lba [47:0], byte_size [79:48]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [zais_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: func [0]
  input  logic [0:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata: cmd_lba [47:0], cmd_blocks [68:48],
  //            buffer_offset_blocks [92:69], next_lba [141:93], zero [143:142]
  output logic [zais_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: status [1:0]
  output logic [1:0]                        out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [zais_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [zais_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [zais_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import zais_pkg::*;

  cfg_t      cfg_r;
  reg_idx_t  reg_idx;
  logic      cfg_wr;

  logic      push;
  q_entry_t  push_entry;
  logic      q_ready;
  logic      q_valid;
  q_entry_t  head;
  logic      pop;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_shift <= SHIFT_W'(9);
      cfg_r.zone_blocks <= 32'd524288;
      cfg_r.read_step   <= STEP_W'(256);
      cfg_r.append_step <= STEP_W'(256);
      cfg_r.win_first   <= '0;
      cfg_r.win_end     <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BLOCK_SHIFT: cfg_r.block_shift <= cfg_pwdata[SHIFT_W-1:0];
        REG_ZONE_BLOCKS: cfg_r.zone_blocks <= cfg_pwdata[31:0];
        REG_READ_STEP:   cfg_r.read_step   <= cfg_pwdata[STEP_W-1:0];
        REG_APPEND_STEP: cfg_r.append_step <= cfg_pwdata[STEP_W-1:0];
        REG_WIN_FIRST:   cfg_r.win_first   <= cfg_pwdata[LBA_W-1:0];
        REG_WIN_END:     cfg_r.win_end     <= cfg_pwdata[LBA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_BLOCK_SHIFT: cfg_prdata = CFG_DATA_W'(cfg_r.block_shift);
      REG_ZONE_BLOCKS: cfg_prdata = CFG_DATA_W'(cfg_r.zone_blocks);
      REG_READ_STEP:   cfg_prdata = CFG_DATA_W'(cfg_r.read_step);
      REG_APPEND_STEP: cfg_prdata = CFG_DATA_W'(cfg_r.append_step);
      REG_WIN_FIRST:   cfg_prdata = CFG_DATA_W'(cfg_r.win_first);
      REG_WIN_END:     cfg_prdata = CFG_DATA_W'(cfg_r.win_end);
      default:         cfg_prdata = '0;
    endcase
  end

  zais_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_func      (in_tuser[0]),
    .in_start_lba (in_tdata[LBA_W-1:0]),
    .in_byte_size (in_tdata[LBA_W+SIZE_W-1:LBA_W]),
    .push         (push),
    .push_entry   (push_entry),
    .q_ready      (q_ready)
  );

  zais_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop        (pop),
    .q_valid    (q_valid),
    .head       (head)
  );

  zais_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  zais_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
